>>> hdl/mhjs_pkg.sv
// Shared types, constants and helpers for the min-heap job scheduler.
package mhjs_pkg;

    localparam int MAX_THREADS = 64;
    localparam int POS_W       = $clog2(MAX_THREADS);
    localparam int BANK_DEPTH  = MAX_THREADS / 2;
    localparam int BANK_AW     = POS_W - 1;

    localparam int WORKER_W = 6;
    localparam int TIME_W   = 64;
    localparam int DUR_W    = 32;
    localparam int CNT_W    = 7;
    localparam int CMP_W    = (POS_W + 2 > CNT_W) ? POS_W + 2 : CNT_W;

    localparam int IN_W     = 32;
    localparam int OUT_W    = 72;
    localparam int OUT_PAD  = OUT_W - WORKER_W - TIME_W;

    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;
    localparam logic REG_ACTIVE_THREADS = 1'b0;

    localparam logic [CNT_W-1:0] ACTIVE_MAX   = CNT_W'(MAX_THREADS);
    localparam logic [CNT_W-1:0] ACTIVE_RESET = (64 < MAX_THREADS) ? CNT_W'(64) : ACTIVE_MAX;

    typedef struct packed {
        logic [TIME_W-1:0]   free_time;
        logic [WORKER_W-1:0] worker;
    } entry_t;

    // controller -> datapath
    typedef struct packed {
        logic load;   // take a new job: root goes out, root + duration starts sifting
        logic step;   // compare at current position and write one heap entry
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic stop;   // sift ends at the current position
    } stat_t;

    // a ranks ahead of b: earlier free time, then lower worker id
    function automatic logic entry_before(entry_t a, entry_t b);
        logic r;
        if (a.free_time != b.free_time) begin
            r = a.free_time < b.free_time;
        end else begin
            r = a.worker < b.worker;
        end
        return r;
    endfunction

endpackage

>>> hdl/mhjs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mhjs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/mhjs_ctrl.sv
// Sequencer for job acceptance, sift-down steps and the result handshake.
module mhjs_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output mhjs_pkg::cmd_t      cmd,
    input  mhjs_pkg::stat_t     stat
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;

    always_comb begin
        cmd.load = accept;
        cmd.step = (state_reg == ST_CMP);
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next   = ST_READ;
                    m_valid_next = 1'b1;
                end
            end
            ST_READ: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                state_next = stat.stop ? ST_IDLE : ST_READ;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

>>> hdl/mhjs_datapath.sv
// Heap storage, sift-down compare/write path, worker count and result register.
module mhjs_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  mhjs_pkg::cmd_t                     cmd,
    output mhjs_pkg::stat_t                    stat,
    input  logic [mhjs_pkg::DUR_W-1:0]         job_duration,
    input  logic                               cfg_we,
    input  logic [mhjs_pkg::CNT_W-1:0]         cfg_wdata,
    output logic [mhjs_pkg::CNT_W-1:0]         active_threads,
    output logic [mhjs_pkg::WORKER_W-1:0]      worker_id,
    output logic [mhjs_pkg::TIME_W-1:0]        start_time
);

    localparam int EW = $bits(mhjs_pkg::entry_t);

    mhjs_pkg::entry_t root_reg, cur_reg, out_reg;
    logic [mhjs_pkg::POS_W-1:0]       pos_reg;
    logic [mhjs_pkg::CNT_W-1:0]       active_reg;
    logic [mhjs_pkg::MAX_THREADS-1:0] valid_reg;

    mhjs_pkg::entry_t odd_rdata, even_rdata;
    mhjs_pkg::entry_t left_e, right_e, best_e, wr_e;
    logic [mhjs_pkg::POS_W+1:0] left_pos, right_pos;
    logic [mhjs_pkg::POS_W-1:0] best_pos;
    logic left_ok, right_ok, l_lt_c, r_lt_c, r_lt_l, take_left, take_right;
    logic [mhjs_pkg::CNT_W-1:0] cfg_sat;
    logic odd_we, even_we;
    logic [mhjs_pkg::BANK_AW-1:0] odd_waddr, even_waddr;

    // children of p: 2p+1 lives in the odd bank, 2p+2 in the even bank, both at index p
    mhjs_ram #(.WIDTH(EW), .DEPTH(mhjs_pkg::BANK_DEPTH)) u_odd_bank (
        .aclk  (aclk),
        .we    (odd_we),
        .waddr (odd_waddr),
        .wdata (wr_e),
        .raddr (pos_reg[mhjs_pkg::BANK_AW-1:0]),
        .rdata (odd_rdata)
    );

    mhjs_ram #(.WIDTH(EW), .DEPTH(mhjs_pkg::BANK_DEPTH)) u_even_bank (
        .aclk  (aclk),
        .we    (even_we),
        .waddr (even_waddr),
        .wdata (wr_e),
        .raddr (pos_reg[mhjs_pkg::BANK_AW-1:0]),
        .rdata (even_rdata)
    );

    always_comb begin
        left_pos  = {1'b0, pos_reg, 1'b1};
        right_pos = {1'b0, pos_reg, 1'b0} + 1'b1 + 1'b1;
        left_ok   = mhjs_pkg::CMP_W'(left_pos)  < mhjs_pkg::CMP_W'(active_reg);
        right_ok  = mhjs_pkg::CMP_W'(right_pos) < mhjs_pkg::CMP_W'(active_reg);

        // never-written slots read as their reset value
        if (valid_reg[left_pos[mhjs_pkg::POS_W-1:0]]) begin
            left_e = odd_rdata;
        end else begin
            left_e.free_time = '0;
            left_e.worker    = mhjs_pkg::WORKER_W'(left_pos);
        end
        if (valid_reg[right_pos[mhjs_pkg::POS_W-1:0]]) begin
            right_e = even_rdata;
        end else begin
            right_e.free_time = '0;
            right_e.worker    = mhjs_pkg::WORKER_W'(right_pos);
        end

        l_lt_c = left_ok  && mhjs_pkg::entry_before(left_e, cur_reg);
        r_lt_c = right_ok && mhjs_pkg::entry_before(right_e, cur_reg);
        r_lt_l = right_ok && mhjs_pkg::entry_before(right_e, left_e);

        take_right = l_lt_c ? r_lt_l : r_lt_c;
        take_left  = l_lt_c && !r_lt_l;

        best_e   = take_right ? right_e : left_e;
        best_pos = take_right ? right_pos[mhjs_pkg::POS_W-1:0]
                              : left_pos[mhjs_pkg::POS_W-1:0];
        stat.stop = !(take_left || take_right);
        wr_e      = stat.stop ? cur_reg : best_e;

        odd_we     = cmd.step && (pos_reg != '0) && pos_reg[0];
        even_we    = cmd.step && (pos_reg != '0) && !pos_reg[0];
        odd_waddr  = pos_reg[mhjs_pkg::POS_W-1:1];
        even_waddr = mhjs_pkg::BANK_AW'(pos_reg[mhjs_pkg::POS_W-1:1] - 1'b1);

        cfg_sat = cfg_wdata;
        if (cfg_wdata == '0) begin
            cfg_sat = mhjs_pkg::CNT_W'(1);
        end else if (cfg_wdata > mhjs_pkg::ACTIVE_MAX) begin
            cfg_sat = mhjs_pkg::ACTIVE_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg         <= mhjs_pkg::ACTIVE_RESET;
            valid_reg          <= '0;
            root_reg.free_time <= '0;
            root_reg.worker    <= '0;
            pos_reg            <= '0;
        end else if (cfg_we) begin
            active_reg         <= cfg_sat;
            valid_reg          <= '0;
            root_reg.free_time <= '0;
            root_reg.worker    <= '0;
            pos_reg            <= '0;
        end else if (cmd.load) begin
            pos_reg <= '0;
        end else if (cmd.step) begin
            valid_reg[pos_reg] <= 1'b1;
            if (pos_reg == '0) begin
                root_reg <= wr_e;
            end
            if (!stat.stop) begin
                pos_reg <= best_pos;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_reg           <= root_reg;
            cur_reg.free_time <= root_reg.free_time + mhjs_pkg::TIME_W'(job_duration);
            cur_reg.worker    <= root_reg.worker;
        end
    end

    assign active_threads = active_reg;
    assign worker_id      = out_reg.worker;
    assign start_time     = out_reg.free_time;

endmodule

>>> hdl/min_heap_job_scheduler.sv
// Top level of the min-heap job scheduler: stream ports, APB register and core.
// A result is presented in the cycle after its job transaction is accepted.
// Per job: the accept, then for each heap level visited one read of both child banks and one
// compare/write step; the root sinks at most 6 levels for 64 workers. No new job is taken until
// the sift is over, and a result waiting on m_tready holds off the next job.
// Reset (aresetn low, synchronous): all workers free at time 0, active_threads = 64.
module min_heap_job_scheduler (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mhjs_pkg::IN_W-1:0]       s_tdata,   // [31:0] job_duration
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mhjs_pkg::OUT_W-1:0]      m_tdata,   // [5:0] worker_id, [69:6] start_time
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mhjs_pkg::APB_AW-1:0]     paddr,
    input  logic [mhjs_pkg::APB_DW-1:0]     pwdata,
    output logic [mhjs_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);

    mhjs_pkg::cmd_t  cmd;
    mhjs_pkg::stat_t stat;
    logic cfg_we;
    logic [mhjs_pkg::CNT_W-1:0]    active_threads;
    logic [mhjs_pkg::WORKER_W-1:0] worker_id;
    logic [mhjs_pkg::TIME_W-1:0]   start_time;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready
                    && (paddr[2] == mhjs_pkg::REG_ACTIVE_THREADS);
    assign prdata = (paddr[2] == mhjs_pkg::REG_ACTIVE_THREADS)
                    ? mhjs_pkg::APB_DW'(active_threads) : '0;

    mhjs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    mhjs_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .job_duration   (s_tdata[mhjs_pkg::DUR_W-1:0]),
        .cfg_we         (cfg_we),
        .cfg_wdata      (pwdata[mhjs_pkg::CNT_W-1:0]),
        .active_threads (active_threads),
        .worker_id      (worker_id),
        .start_time     (start_time)
    );

    assign m_tdata = {{mhjs_pkg::OUT_PAD{1'b0}}, start_time, worker_id};

endmodule

>>> verif/testbench.sv
// Self-checking stream/APB testbench for the min-heap job scheduler.
module testbench;

    localparam int CLK_PERIOD  = 20;
    localparam int RESET_TICKS = 6;
    localparam int CFG_QUIET   = 20;      // idle cycles before a register write
    localparam int TAIL_TICKS  = 32;
    localparam int LIMIT_TICKS = 400000;
    localparam logic [mhjs_pkg::APB_AW-1:0] ADDR_ACTIVE_THREADS =
        {mhjs_pkg::REG_ACTIVE_THREADS, 2'b00};
    localparam logic [mhjs_pkg::APB_AW-1:0] ADDR_UNMAPPED       = 3'd4;

    typedef enum logic [1:0] {ACT_JOB, ACT_CFG_WRITE, ACT_PACING} act_t;
    typedef enum logic [1:0] {APB_IDLE, APB_SETUP, APB_ACCESS} apb_stage_t;

    typedef struct {
        act_t                        act;
        logic [mhjs_pkg::APB_AW-1:0] addr;
        logic [31:0]                 data;
        int                          idle_pct;
        int                          stall_pct;
    } stim_t;

    typedef struct {
        logic [mhjs_pkg::WORKER_W-1:0] worker_id;
        logic [mhjs_pkg::TIME_W-1:0]   start_time;
    } assignment_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [mhjs_pkg::IN_W-1:0]     s_tdata  = '0;   // [31:0] job_duration
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [mhjs_pkg::OUT_W-1:0]    m_tdata;         // [5:0] worker_id, [69:6] start_time
    logic                          psel     = 1'b0;
    logic                          penable  = 1'b0;
    logic                          pwrite   = 1'b0;
    logic [mhjs_pkg::APB_AW-1:0]   paddr    = '0;
    logic [mhjs_pkg::APB_DW-1:0]   pwdata   = '0;
    logic [mhjs_pkg::APB_DW-1:0]   prdata;
    logic                          pready;

    stim_t             stim_q[$];
    assignment_t       due_assignments[$];
    mhjs_pkg::entry_t  sched_heap[mhjs_pkg::MAX_THREADS];
    int                workers_active;
    int                send_idle_pct  = 0;
    int                recv_stall_pct = 0;
    int                fail_count     = 0;
    int                drain_cnt      = 0;
    logic              job_taken      = 1'b0;
    apb_stage_t        apb_stage      = APB_IDLE;

    min_heap_job_scheduler dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ---------------- scheduler prediction ----------------

    function automatic void reload_heap(input logic [31:0] value);
        int n;
        n = int'(value[6:0]);
        if (n == 0) n = 1;
        if (n > mhjs_pkg::MAX_THREADS) n = mhjs_pkg::MAX_THREADS;
        workers_active = n;
        for (int k = 0; k < mhjs_pkg::MAX_THREADS; k++) begin
            sched_heap[k].free_time = '0;
            sched_heap[k].worker    = mhjs_pkg::WORKER_W'(k);
        end
    endfunction

    function automatic assignment_t dispatch_job(input logic [mhjs_pkg::DUR_W-1:0] duration);
        assignment_t       res;
        mhjs_pkg::entry_t  tmp;
        int                pos;
        int                best;
        logic              settled;
        res.worker_id  = sched_heap[0].worker;
        res.start_time = sched_heap[0].free_time;
        sched_heap[0].free_time = sched_heap[0].free_time + mhjs_pkg::TIME_W'(duration);
        pos = 0;
        settled = 1'b0;
        while (!settled) begin
            best = pos;
            for (int kid = 2 * pos + 1; kid <= 2 * pos + 2; kid++) begin
                if (kid < workers_active &&
                    (sched_heap[kid].free_time < sched_heap[best].free_time ||
                     (sched_heap[kid].free_time == sched_heap[best].free_time &&
                      sched_heap[kid].worker < sched_heap[best].worker))) begin
                    best = kid;
                end
            end
            if (best == pos) begin
                settled = 1'b1;
            end else begin
                tmp = sched_heap[pos];
                sched_heap[pos] = sched_heap[best];
                sched_heap[best] = tmp;
                pos = best;
            end
        end
        return res;
    endfunction

    // ---------------- stimulus queue ----------------

    task automatic add_job(input logic [31:0] duration);
        stim_t it;
        it = '{ACT_JOB, '0, duration, 0, 0};
        stim_q.push_back(it);
    endtask

    task automatic add_cfg(input logic [mhjs_pkg::APB_AW-1:0] addr, input logic [31:0] value);
        stim_t it;
        it = '{ACT_CFG_WRITE, addr, value, 0, 0};
        stim_q.push_back(it);
    endtask

    task automatic add_pacing(input int idle_pct, input int stall_pct);
        stim_t it;
        it = '{ACT_PACING, '0, '0, idle_pct, stall_pct};
        stim_q.push_back(it);
    endtask

    function automatic logic [31:0] rand_duration();
        logic [31:0] d;
        case ($urandom_range(4))
            0: d = $urandom_range(3);           // lots of ties
            1: d = $urandom_range(1000);
            2: d = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
            default: d = $urandom;
        endcase
        return d;
    endfunction

    // ---------------- driver ----------------

    always @(negedge aclk) begin
        logic                      nxt_valid;
        logic [mhjs_pkg::IN_W-1:0] nxt_data;
        stim_t                     head;
        nxt_valid = s_tvalid;
        nxt_data  = s_tdata;
        if (aresetn) begin
            if (s_tvalid && job_taken) nxt_valid = 1'b0;
            case (apb_stage)
                APB_SETUP: begin
                    penable   <= 1'b1;
                    apb_stage <= APB_ACCESS;
                end
                APB_ACCESS: begin
                    psel      <= 1'b0;
                    penable   <= 1'b0;
                    pwrite    <= 1'b0;
                    apb_stage <= APB_IDLE;
                end
                default: begin
                    if (!nxt_valid && stim_q.size() > 0) begin
                        head = stim_q[0];
                        case (head.act)
                            ACT_PACING: begin
                                send_idle_pct  <= head.idle_pct;
                                recv_stall_pct <= head.stall_pct;
                                void'(stim_q.pop_front());
                            end
                            ACT_JOB: begin
                                if ($urandom_range(99) >= send_idle_pct) begin
                                    nxt_valid = 1'b1;
                                    nxt_data  = head.data;
                                    void'(stim_q.pop_front());
                                end
                            end
                            default: begin
                                // block must be drained before the heap is reinitialized
                                if (drain_cnt >= CFG_QUIET) begin
                                    psel      <= 1'b1;
                                    pwrite    <= 1'b1;
                                    paddr     <= head.addr;
                                    pwdata    <= head.data;
                                    apb_stage <= APB_SETUP;
                                    void'(stim_q.pop_front());
                                end
                            end
                        endcase
                    end
                end
            endcase
        end
        s_tvalid <= nxt_valid;
        s_tdata  <= nxt_data;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ---------------- monitor / checker ----------------

    always @(posedge aclk) begin
        assignment_t got;
        assignment_t want;
        job_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (psel && penable && pwrite && pready &&
                paddr[mhjs_pkg::APB_AW-1:2] == 1'b0 &&
                paddr[2] == mhjs_pkg::REG_ACTIVE_THREADS) begin
                reload_heap(pwdata);
            end
            if (s_tvalid && s_tready) begin
                due_assignments.push_back(dispatch_job(s_tdata[mhjs_pkg::DUR_W-1:0]));
            end
            if (m_tvalid && m_tready) begin
                got.worker_id  = m_tdata[mhjs_pkg::WORKER_W-1:0];
                got.start_time = m_tdata[mhjs_pkg::WORKER_W +: mhjs_pkg::TIME_W];
                if (due_assignments.size() == 0) begin
                    $error("unexpected result transaction: worker_id %0d start_time %0d",
                           got.worker_id, got.start_time);
                    fail_count++;
                end else begin
                    want = due_assignments.pop_front();
                    if (got.worker_id !== want.worker_id) begin
                        $error("worker_id: expected %0d, got %0d",
                               want.worker_id, got.worker_id);
                        fail_count++;
                    end
                    if (got.start_time !== want.start_time) begin
                        $error("start_time: expected %0d, got %0d",
                               want.start_time, got.start_time);
                        fail_count++;
                    end
                end
            end
            if (due_assignments.size() == 0 && !s_tvalid && apb_stage == APB_IDLE) begin
                if (drain_cnt < CFG_QUIET) drain_cnt <= drain_cnt + 1;
            end else begin
                drain_cnt <= 0;
            end
        end
    end

    // ---------------- sequence ----------------

    initial begin
        logic [31:0] count;
        reload_heap(32'd64);

        // directed: all workers idle at 64, ties resolve by id
        add_pacing(0, 0);
        add_job(32'h0);
        add_job(32'h0);
        add_job(32'h0);
        add_job(32'hFFFF_FFFF);
        add_job(32'h1);
        add_job(32'h8000_0000);
        add_job(32'h7FFF_FFFF);
        add_job(32'hAAAA_AAAA);
        add_job(32'h5555_5555);
        // zero count clamps to a single worker
        add_cfg(ADDR_ACTIVE_THREADS, 32'd0);
        add_job(32'hFFFF_FFFF);
        add_job(32'hFFFF_FFFF);
        add_job(32'd5);
        // unmapped register is ignored, heap keeps running
        add_cfg(ADDR_UNMAPPED, 32'd3);
        add_job(32'd7);
        // only the low 7 bits count; 0x02 -> two workers
        add_cfg(ADDR_ACTIVE_THREADS, 32'hFFFF_FF82);
        add_job(32'd3);
        add_job(32'd3);
        add_job(32'd0);
        add_job(32'd1);
        // oversized count clamps to the maximum
        add_cfg(ADDR_ACTIVE_THREADS, 32'd127);
        add_job(32'd0);
        add_job(32'd9);
        add_job(32'd0);

        // random phases over the idling modes
        for (int mode = 0; mode < 4; mode++) begin
            case (mode)
                0: add_pacing(0, 0);
                1: add_pacing(51, 0);
                2: add_pacing(0, 51);
                default: add_pacing(34, 34);
            endcase
            for (int seg = 0; seg < 2; seg++) begin
                case ($urandom_range(4))
                    0: count = 32'd1;
                    1: count = 32'd64;
                    2: count = $urandom;
                    default: count = $urandom_range(1, 64);
                endcase
                if (mode == 0) count = (seg == 0) ? 32'd1 : 32'd64;
                if ($urandom_range(7) == 0) add_cfg(ADDR_UNMAPPED, $urandom);
                add_cfg(ADDR_ACTIVE_THREADS, count);
                repeat (56) add_job(rand_duration());
            end
        end

        repeat (RESET_TICKS) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (stim_q.size() != 0 || s_tvalid || apb_stage != APB_IDLE ||
               due_assignments.size() != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_TICKS) @(posedge aclk);

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #(CLK_PERIOD * LIMIT_TICKS);
        $display("timeout waiting for scheduler results");
        $display("== FAIL ==");
        $finish;
    end

endmodule

>>> filelist.f
hdl/mhjs_pkg.sv
hdl/mhjs_ram.sv
hdl/mhjs_ctrl.sv
hdl/mhjs_datapath.sv
hdl/min_heap_job_scheduler.sv
verif/testbench.sv
